@@ src/backflush_cleaning_sequencer_top_macros.svh @@
// ----------------------------------------------------------------------------
// backflush_cleaning_sequencer_top_macros
// Assertion macros for the backflush cleaning sequencer.
// ----------------------------------------------------------------------------
// Both macros sample on the rising edge of clk and are held off while arst_n is low.
`ifndef BACKFLUSH_CLEANING_SEQUENCER_TOP_MACROS_SVH
`define BACKFLUSH_CLEANING_SEQUENCER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// Types, constants and code helpers for the backflush cleaning sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

	localparam int PRESS_W = 12;
	localparam int TICK_W  = 24;
	localparam int IDX_W   = 6;
	localparam int LEVEL_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 40;

	localparam logic [TICK_W-1:0]   TICK_MAX    = '1;
	localparam logic [PRESS_W:0]    HARD_MARGIN = 13'd100;
	localparam logic                MOMENTARY_BUTTON = 1'b1;
	localparam logic [LEVEL_W-1:0]  FULL_LEVEL  = 8'd255;

	// Output codes
	localparam logic [2:0] PC_NONE  = 3'd0;
	localparam logic [2:0] PC_DET   = 3'd1;
	localparam logic [2:0] PC_SOAK  = 3'd2;
	localparam logic [2:0] PC_AWAIT = 3'd3;
	localparam logic [2:0] PC_RINSE = 3'd4;
	localparam logic [2:0] PC_DONE  = 3'd5;
	localparam logic [1:0] FC_OFF   = 2'd0;
	localparam logic [1:0] FC_PRESS = 2'd1;
	localparam logic [1:0] FC_HOLD  = 2'd2;
	localparam logic [1:0] FC_REL   = 2'd3;

	typedef enum logic [5:0] {
		PH_NONE  = 6'b000001,
		PH_DET   = 6'b000010,
		PH_SOAK  = 6'b000100,
		PH_AWAIT = 6'b001000,
		PH_RINSE = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	typedef enum logic [3:0] {
		FS_OFF   = 4'b0001,
		FS_PRESS = 4'b0010,
		FS_HOLD  = 4'b0100,
		FS_REL   = 4'b1000
	} flush_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PRESSURE  = 3'd0,
		REG_FILL_TIMEOUT  = 3'd1,
		REG_HOLD_TICKS    = 3'd2,
		REG_HOLD_LEVEL    = 3'd3,
		REG_PAUSE_TICKS   = 3'd4,
		REG_FLUSHES       = 3'd5,
		REG_SOAK_TICKS    = 3'd6,
		REG_AWAIT_TIMEOUT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [PRESS_W-1:0] max_pressure;
		logic [TICK_W-1:0]  fill_timeout_ticks;
		logic [TICK_W-1:0]  hold_ticks;
		logic [LEVEL_W-1:0] hold_pump_level;
		logic [TICK_W-1:0]  pause_ticks;
		logic [IDX_W-1:0]   flushes_per_phase;
		logic [TICK_W-1:0]  soak_ticks;
		logic [TICK_W-1:0]  await_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		flush_t             fs;
		logic [IDX_W-1:0]   flush_index;
		logic [TICK_W-1:0]  elapsed;
		logic               believed_on;
		logic [PRESS_W-1:0] fill_peak;
		logic [PRESS_W-1:0] last_peak;
		logic               last_max;
		logic               latch_level;
	} seq_state_t;

	// Input word layout, lowest bit last in the list
	typedef struct packed {
		logic [6:0]         pad;
		logic               brewing;
		logic               button_abort;
		logic               continue_req;
		logic               stop_req;
		logic               start_req;
		logic [PRESS_W-1:0] pressure;
	} item_t;

	// Result word layout, lowest bit last in the list
	typedef struct packed {
		logic [3:0]         pad;
		logic               active;
		logic               last_reached_max;
		logic [PRESS_W-1:0] last_peak;
		logic [6:0]         cycle_number;
		logic [1:0]         flush_state;
		logic [2:0]         phase_code;
		logic [LEVEL_W-1:0] pump_level;
		logic               button_drive;
		logic               machine_on;
	} result_t;

	function automatic logic is_active(input phase_t ph);
		return (ph == PH_DET) || (ph == PH_SOAK) || (ph == PH_AWAIT) || (ph == PH_RINSE);
	endfunction

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] c;
		case (ph)
			PH_DET:   c = PC_DET;
			PH_SOAK:  c = PC_SOAK;
			PH_AWAIT: c = PC_AWAIT;
			PH_RINSE: c = PC_RINSE;
			PH_DONE:  c = PC_DONE;
			default:  c = PC_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] flush_code(input flush_t fs);
		logic [1:0] c;
		case (fs)
			FS_PRESS: c = FC_PRESS;
			FS_HOLD:  c = FC_HOLD;
			FS_REL:   c = FC_REL;
			default:  c = FC_OFF;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/bcs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bcs_cfg_regs
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcs_pkg::TICK_W-1:0]     cfg_data,
	output bcs_pkg::cfg_t                       cfg
);

	bcs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pressure        <= 12'd900;
			cfg_q.fill_timeout_ticks  <= 24'd1000;
			cfg_q.hold_ticks          <= 24'd500;
			cfg_q.hold_pump_level     <= 8'd120;
			cfg_q.pause_ticks         <= 24'd1000;
			cfg_q.flushes_per_phase   <= 6'd5;
			cfg_q.soak_ticks          <= 24'd6000;
			cfg_q.await_timeout_ticks <= 24'd60000;
		end else if (cfg_valid) begin
			case (bcs_pkg::cfg_reg_t'(cfg_index))
				bcs_pkg::REG_MAX_PRESSURE:
					cfg_q.max_pressure <= cfg_data[bcs_pkg::PRESS_W-1:0];
				bcs_pkg::REG_FILL_TIMEOUT:  cfg_q.fill_timeout_ticks <= cfg_data;
				bcs_pkg::REG_HOLD_TICKS:    cfg_q.hold_ticks <= cfg_data;
				bcs_pkg::REG_HOLD_LEVEL:
					cfg_q.hold_pump_level <= cfg_data[bcs_pkg::LEVEL_W-1:0];
				bcs_pkg::REG_PAUSE_TICKS:   cfg_q.pause_ticks <= cfg_data;
				bcs_pkg::REG_FLUSHES:
					cfg_q.flushes_per_phase <= cfg_data[bcs_pkg::IDX_W-1:0];
				bcs_pkg::REG_SOAK_TICKS:    cfg_q.soak_ticks <= cfg_data;
				bcs_pkg::REG_AWAIT_TIMEOUT: cfg_q.await_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/bcs_step.sv @@
// ----------------------------------------------------------------------------
// bcs_step
// One control tick: request handling, flush sequencing and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_step (
	input  wire bcs_pkg::seq_state_t st,
	input  wire bcs_pkg::cfg_t       cfg,
	input  wire bcs_pkg::item_t      item,
	output bcs_pkg::seq_state_t      st_next,
	output bcs_pkg::result_t         res
);

	// Returns {believed_on, toggle, latch_level} after asking for drive level on
	function automatic logic [2:0] drive(input logic on, input logic bon,
			input logic tog, input logic latch);
		logic [2:0] r;
		r = {bon, tog, latch};
		if (on != bon) begin
			if (bcs_pkg::MOMENTARY_BUTTON)
				r[1] = ~tog;
			else
				r[0] = on;
			r[2] = on;
		end
		return r;
	endfunction

	bcs_pkg::seq_state_t s;
	logic                tog;
	logic [bcs_pkg::PRESS_W-1:0] p;
	logic [bcs_pkg::PRESS_W:0]   hard_limit;

	assign p          = item.pressure;
	assign hard_limit = {1'b0, cfg.max_pressure} + bcs_pkg::HARD_MARGIN;

	always_comb begin
		s   = st;
		tog = 1'b0;
		if (s.elapsed != bcs_pkg::TICK_MAX)
			s.elapsed = s.elapsed + 24'd1;

		// button abort: stop without a toggle pulse
		if (item.button_abort && bcs_pkg::is_active(s.phase)) begin
			if (!bcs_pkg::MOMENTARY_BUTTON)
				s.latch_level = 1'b0;
			s.phase       = bcs_pkg::PH_NONE;
			s.fs          = bcs_pkg::FS_OFF;
			s.flush_index = '0;
			s.believed_on = 1'b0;
		end

		if (item.stop_req && bcs_pkg::is_active(s.phase)) begin
			{s.believed_on, tog, s.latch_level} = drive(1'b0, s.believed_on, tog, s.latch_level);
			s.phase       = bcs_pkg::PH_NONE;
			s.fs          = bcs_pkg::FS_OFF;
			s.flush_index = '0;
			s.believed_on = 1'b0;
		end

		if (item.start_req && !bcs_pkg::is_active(s.phase) && !item.brewing) begin
			s.phase       = bcs_pkg::PH_DET;
			s.flush_index = '0;
			s.last_peak   = '0;
			s.last_max    = 1'b0;
			s.fill_peak   = '0;
			{s.believed_on, tog, s.latch_level} = drive(1'b1, s.believed_on, tog, s.latch_level);
			s.fs          = bcs_pkg::FS_PRESS;
			s.elapsed     = '0;
		end

		if (item.continue_req && s.phase == bcs_pkg::PH_AWAIT) begin
			s.phase       = bcs_pkg::PH_RINSE;
			s.flush_index = '0;
			s.fill_peak   = '0;
			{s.believed_on, tog, s.latch_level} = drive(1'b1, s.believed_on, tog, s.latch_level);
			s.fs          = bcs_pkg::FS_PRESS;
			s.elapsed     = '0;
		end

		if (bcs_pkg::is_active(s.phase)) begin
			if (s.believed_on && ({1'b0, p} > hard_limit)) begin
				// overpressure: vent at once
				s.last_peak = (s.fill_peak > p) ? s.fill_peak : p;
				s.last_max  = 1'b1;
				{s.believed_on, tog, s.latch_level} = drive(1'b0, s.believed_on, tog, s.latch_level);
				s.fs      = bcs_pkg::FS_REL;
				s.elapsed = '0;
			end else begin
				case (s.fs)
					bcs_pkg::FS_PRESS: begin
						if (p > s.fill_peak)
							s.fill_peak = p;
						if (p >= cfg.max_pressure) begin
							s.last_peak = s.fill_peak;
							s.last_max  = 1'b1;
							s.fs        = bcs_pkg::FS_HOLD;
							s.elapsed   = '0;
						end else if (s.elapsed > cfg.fill_timeout_ticks) begin
							s.last_peak = s.fill_peak;
							s.last_max  = 1'b0;
							{s.believed_on, tog, s.latch_level} =
								drive(1'b0, s.believed_on, tog, s.latch_level);
							s.fs      = bcs_pkg::FS_REL;
							s.elapsed = '0;
						end
					end
					bcs_pkg::FS_HOLD: begin
						if (p > s.fill_peak) begin
							s.fill_peak = p;
							s.last_peak = p;
						end
						if (s.elapsed > cfg.hold_ticks) begin
							{s.believed_on, tog, s.latch_level} =
								drive(1'b0, s.believed_on, tog, s.latch_level);
							s.fs      = bcs_pkg::FS_REL;
							s.elapsed = '0;
						end
					end
					bcs_pkg::FS_REL: begin
						if (s.elapsed > cfg.pause_ticks) begin
							s.flush_index = s.flush_index + 6'd1;
							if (s.flush_index < cfg.flushes_per_phase) begin
								s.fill_peak = '0;
								{s.believed_on, tog, s.latch_level} =
									drive(1'b1, s.believed_on, tog, s.latch_level);
								s.fs      = bcs_pkg::FS_PRESS;
								s.elapsed = '0;
							end else if (s.phase == bcs_pkg::PH_DET) begin
								s.phase   = bcs_pkg::PH_SOAK;
								s.fs      = bcs_pkg::FS_OFF;
								s.elapsed = '0;
							end else begin
								s.phase       = bcs_pkg::PH_DONE;
								s.fs          = bcs_pkg::FS_OFF;
								s.flush_index = '0;
								s.believed_on = 1'b0;
							end
						end
					end
					default: begin
						if (s.phase == bcs_pkg::PH_SOAK && s.elapsed > cfg.soak_ticks) begin
							s.phase   = bcs_pkg::PH_AWAIT;
							s.elapsed = '0;
						end else if (s.phase == bcs_pkg::PH_AWAIT &&
								s.elapsed > cfg.await_timeout_ticks) begin
							s.phase       = bcs_pkg::PH_NONE;
							s.fs          = bcs_pkg::FS_OFF;
							s.flush_index = '0;
							s.believed_on = 1'b0;
						end
					end
				endcase
			end
		end
	end

	assign st_next = s;

	always_comb begin
		res                  = '0;
		res.machine_on       = s.believed_on;
		res.button_drive     = bcs_pkg::MOMENTARY_BUTTON ? tog : s.latch_level;
		res.pump_level       = (s.fs == bcs_pkg::FS_HOLD) ? cfg.hold_pump_level
			: bcs_pkg::FULL_LEVEL;
		res.phase_code       = bcs_pkg::phase_code(s.phase);
		res.flush_state      = bcs_pkg::flush_code(s.fs);
		res.cycle_number     = {1'b0, s.flush_index} + 7'd1;
		res.last_peak        = s.last_peak;
		res.last_reached_max = s.last_max;
		res.active           = bcs_pkg::is_active(s.phase);
	end

endmodule

`default_nettype wire

@@ src/backflush_cleaning_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// backflush_cleaning_sequencer_top
// Backflush cleaning sequencer: one control tick per stream word.
// ----------------------------------------------------------------------------
// Each input word is one control tick and yields exactly one result word that
// shows the sequencer state after that tick. The block takes one word per
// clock cycle unless m_tready holds the output register full; an accepted
// word waits in the input register, then a single pass of tick logic writes
// its result into the output register and updates the state registers. The
// output register lets a new word enter while a result waits. The
// configuration channel is always ready and should only be written while no
// ticks are in flight. Everything is ready straight out of reset.
`default_nettype none

module backflush_cleaning_sequencer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcs_pkg::TICK_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// pressure[11:0], start_req, stop_req, continue_req, button_abort, brewing, zero pad
	input  wire logic [bcs_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// machine_on, button_drive, pump_level[7:0], phase_code[2:0], flush_state[1:0],
	// cycle_number[6:0], last_peak[11:0], last_reached_max, active, zero pad
	output logic [bcs_pkg::M_DATA_W-1:0]        m_tdata
);

	bcs_pkg::cfg_t       cfg;
	bcs_pkg::seq_state_t state_q;
	bcs_pkg::seq_state_t state_next;
	bcs_pkg::result_t    res;

	logic                          valid_s1;
	logic [bcs_pkg::S_DATA_W-1:0]  tdata_s1;
	logic                          m_tvalid_q;
	logic [bcs_pkg::M_DATA_W-1:0]  m_tdata_q;
	logic                          adv;

	bcs_pkg::result_t              out_word;
	logic                          flushing;
	logic                          in_flush_phase;
	logic                          active_ok;

	bcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcs_step u_step (
		.st      (state_q),
		.cfg     (cfg),
		.item    (bcs_pkg::item_t'(tdata_s1)),
		.st_next (state_next),
		.res     (res)
	);

	// process the held word when the output register is free or being emptied
	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			tdata_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= bcs_pkg::PH_NONE;
			state_q.fs          <= bcs_pkg::FS_OFF;
			state_q.flush_index <= '0;
			state_q.elapsed     <= '0;
			state_q.believed_on <= 1'b0;
			state_q.fill_peak   <= '0;
			state_q.last_peak   <= '0;
			state_q.last_max    <= 1'b0;
			state_q.latch_level <= 1'b0;
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			m_tdata_q <= res;
	end

	assign out_word       = bcs_pkg::result_t'(m_tdata_q);
	assign flushing       = (state_q.fs != bcs_pkg::FS_OFF);
	assign in_flush_phase = (state_q.phase == bcs_pkg::PH_DET) ||
		(state_q.phase == bcs_pkg::PH_RINSE);
	assign active_ok      = out_word.active == ((out_word.phase_code != bcs_pkg::PC_NONE) &&
		(out_word.phase_code != bcs_pkg::PC_DONE));

`include "backflush_cleaning_sequencer_top_macros.svh"

	`BCS_ASSERT_NEXT(a_adv_loads_result, adv, m_tvalid_q, "processed tick produced no result")
	`BCS_ASSERT_NEXT(a_state_holds, !adv, $stable(state_q), "state moved without a tick")
	`BCS_ASSERT_NOW(a_flush_in_phase, flushing, in_flush_phase, "flush outside a flush phase")
	`BCS_ASSERT_NOW(a_active_matches_phase, m_tvalid_q, active_ok, "active flag disagrees")

endmodule

`default_nettype wire

@@ tb/tb_backflush_cleaning_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// tb_backflush_cleaning_sequencer_top
// Self-checking bench for the backflush cleaning sequencer. Control ticks are
// streamed in with random gaps. Each accepted tick is run through a cycle-free
// model of the cleaning program, which queues the status word it expects.
// Every status word that leaves the block is checked field by field against
// the oldest queued one. The first run uses reset values; later settings are
// loaded after the block drains: all zero, all at maximum, then random ones.
// ----------------------------------------------------------------------------

module tb_backflush_cleaning_sequencer_top;

	localparam int PRESS_W   = bcs_pkg::PRESS_W;
	localparam int TICK_W    = bcs_pkg::TICK_W;
	localparam int IDX_W     = bcs_pkg::IDX_W;
	localparam int LEVEL_W   = bcs_pkg::LEVEL_W;
	localparam int CFG_IDX_W = bcs_pkg::CFG_IDX_W;
	localparam int S_DATA_W  = bcs_pkg::S_DATA_W;
	localparam int M_DATA_W  = bcs_pkg::M_DATA_W;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int TAIL_CYCLES    = 10;
	localparam int NOISE_QUIET    = 3;
	localparam int NOISE_ROUGH    = 60;
	localparam int RANDOM_RUNS    = 14;
	localparam int TICKS_PER_RUN  = 130;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;

	// Model of the sequencer
	bcs_pkg::cfg_t      seq_cfg;
	logic [2:0]         seq_phase;
	logic [1:0]         seq_flush;
	logic [IDX_W-1:0]   seq_index;
	logic [TICK_W-1:0]  seq_elapsed;
	logic               seq_on;
	logic [PRESS_W-1:0] seq_peak;
	logic [PRESS_W-1:0] seq_last_peak;
	logic               seq_last_max;
	logic               seq_latch;
	logic               seq_pulse;

	bcs_pkg::result_t status_queue[$];
	int      fail_count  = 0;
	int      cycle_count = 0;
	int      sink_hold   = 0;
	bit      feed_gaps   = 1'b0;
	bit      sink_stalls = 1'b0;

	backflush_cleaning_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Sequencer model
	// ------------------------------------------------------------------
	function void reset_sequencer();
		seq_cfg.max_pressure        = 12'd900;
		seq_cfg.fill_timeout_ticks  = 24'd1000;
		seq_cfg.hold_ticks          = 24'd500;
		seq_cfg.hold_pump_level     = 8'd120;
		seq_cfg.pause_ticks         = 24'd1000;
		seq_cfg.flushes_per_phase   = 6'd5;
		seq_cfg.soak_ticks          = 24'd6000;
		seq_cfg.await_timeout_ticks = 24'd60000;
		seq_phase     = bcs_pkg::PC_NONE;
		seq_flush     = bcs_pkg::FC_OFF;
		seq_index     = '0;
		seq_elapsed   = '0;
		seq_on        = 1'b0;
		seq_peak      = '0;
		seq_last_peak = '0;
		seq_last_max  = 1'b0;
		seq_latch     = 1'b0;
		seq_pulse     = 1'b0;
	endfunction

	function void store_setting(input bcs_pkg::cfg_reg_t idx, input logic [TICK_W-1:0] v);
		case (idx)
			bcs_pkg::REG_MAX_PRESSURE:  seq_cfg.max_pressure        = v[PRESS_W-1:0];
			bcs_pkg::REG_FILL_TIMEOUT:  seq_cfg.fill_timeout_ticks  = v;
			bcs_pkg::REG_HOLD_TICKS:    seq_cfg.hold_ticks          = v;
			bcs_pkg::REG_HOLD_LEVEL:    seq_cfg.hold_pump_level     = v[LEVEL_W-1:0];
			bcs_pkg::REG_PAUSE_TICKS:   seq_cfg.pause_ticks         = v;
			bcs_pkg::REG_FLUSHES:       seq_cfg.flushes_per_phase   = v[IDX_W-1:0];
			bcs_pkg::REG_SOAK_TICKS:    seq_cfg.soak_ticks          = v;
			bcs_pkg::REG_AWAIT_TIMEOUT: seq_cfg.await_timeout_ticks = v;
			default: ;
		endcase
	endfunction

	function automatic logic seq_active();
		return (seq_phase >= bcs_pkg::PC_DET) && (seq_phase <= bcs_pkg::PC_RINSE);
	endfunction

	// Two changes of the machine in one tick cancel the toggle pulse
	function void drive_on(input logic on);
		if (on != seq_on) begin
			if (bcs_pkg::MOMENTARY_BUTTON)
				seq_pulse = ~seq_pulse;
			else
				seq_latch = on;
			seq_on = on;
		end
	endfunction

	function void enter_flush(input logic [1:0] st);
		seq_flush   = st;
		seq_elapsed = '0;
	endfunction

	function void stop_program();
		seq_phase = bcs_pkg::PC_NONE;
		seq_flush = bcs_pkg::FC_OFF;
		seq_index = '0;
		seq_on    = 1'b0;
	endfunction

	function void open_flush();
		seq_peak = '0;
		drive_on(1'b1);
		enter_flush(bcs_pkg::FC_PRESS);
	endfunction

	function void close_flush();
		seq_index = seq_index + 1'b1;
		if (seq_index < seq_cfg.flushes_per_phase) begin
			open_flush();
		end else if (seq_phase == bcs_pkg::PC_DET) begin
			seq_phase   = bcs_pkg::PC_SOAK;
			seq_flush   = bcs_pkg::FC_OFF;
			seq_elapsed = '0;
		end else begin
			stop_program();
			seq_phase = bcs_pkg::PC_DONE;
		end
	endfunction

	function void end_fill(input logic reached);
		seq_last_peak = seq_peak;
		seq_last_max  = reached;
		if (reached) begin
			enter_flush(bcs_pkg::FC_HOLD);
		end else begin
			drive_on(1'b0);
			enter_flush(bcs_pkg::FC_REL);
		end
	endfunction

	function void run_program(input logic [PRESS_W-1:0] p);
		logic [TICK_W-1:0] e;
		e = seq_elapsed;
		// overpressure vents at once, whatever the flush state
		if (seq_on && ({1'b0, p} >
				{1'b0, seq_cfg.max_pressure} + bcs_pkg::HARD_MARGIN)) begin
			seq_last_peak = (seq_peak > p) ? seq_peak : p;
			seq_last_max  = 1'b1;
			drive_on(1'b0);
			enter_flush(bcs_pkg::FC_REL);
		end else begin
			case (seq_flush)
				bcs_pkg::FC_PRESS: begin
					if (p > seq_peak)
						seq_peak = p;
					if (p >= seq_cfg.max_pressure)
						end_fill(1'b1);
					else if (e > seq_cfg.fill_timeout_ticks)
						end_fill(1'b0);
				end
				bcs_pkg::FC_HOLD: begin
					if (p > seq_peak) begin
						seq_peak      = p;
						seq_last_peak = p;
					end
					if (e > seq_cfg.hold_ticks) begin
						drive_on(1'b0);
						enter_flush(bcs_pkg::FC_REL);
					end
				end
				bcs_pkg::FC_REL: begin
					if (e > seq_cfg.pause_ticks)
						close_flush();
				end
				default: begin
					if (seq_phase == bcs_pkg::PC_SOAK && e > seq_cfg.soak_ticks) begin
						seq_phase   = bcs_pkg::PC_AWAIT;
						seq_elapsed = '0;
					end else if (seq_phase == bcs_pkg::PC_AWAIT &&
							e > seq_cfg.await_timeout_ticks) begin
						stop_program();
					end
				end
			endcase
		end
	endfunction

	// One control tick; returns the status word the block should emit for it
	function bcs_pkg::result_t advance_sequencer(input bcs_pkg::item_t it);
		bcs_pkg::result_t r;
		seq_pulse = 1'b0;
		if (seq_elapsed != bcs_pkg::TICK_MAX)
			seq_elapsed = seq_elapsed + 1'b1;
		if (it.button_abort && seq_active()) begin
			if (!bcs_pkg::MOMENTARY_BUTTON)
				seq_latch = 1'b0;
			stop_program();
		end
		if (it.stop_req && seq_active()) begin
			drive_on(1'b0);
			stop_program();
		end
		if (it.start_req && !seq_active() && !it.brewing) begin
			seq_phase     = bcs_pkg::PC_DET;
			seq_index     = '0;
			seq_last_peak = '0;
			seq_last_max  = 1'b0;
			open_flush();
		end
		if (it.continue_req && seq_phase == bcs_pkg::PC_AWAIT) begin
			seq_phase = bcs_pkg::PC_RINSE;
			seq_index = '0;
			open_flush();
		end
		if (seq_active())
			run_program(it.pressure);

		r = '0;
		r.machine_on       = seq_on;
		r.button_drive     = bcs_pkg::MOMENTARY_BUTTON ? seq_pulse : seq_latch;
		r.pump_level       = (seq_flush == bcs_pkg::FC_HOLD) ? seq_cfg.hold_pump_level
			: bcs_pkg::FULL_LEVEL;
		r.phase_code       = seq_phase;
		r.flush_state      = seq_flush;
		r.cycle_number     = {1'b0, seq_index} + 7'd1;
		r.last_peak        = seq_last_peak;
		r.last_reached_max = seq_last_max;
		r.active           = seq_active();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_error(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_error($sformatf("%s is %0d, should be %0d", name, got, want));
	endtask

	task automatic check_status(input bcs_pkg::result_t got);
		bcs_pkg::result_t want;
		if (status_queue.size() == 0) begin
			report_error($sformatf("status word %h with no tick outstanding", got));
			return;
		end
		want = status_queue.pop_front();
		compare_field("machine_on", 32'(got.machine_on), 32'(want.machine_on));
		compare_field("button_drive", 32'(got.button_drive), 32'(want.button_drive));
		compare_field("pump_level", 32'(got.pump_level), 32'(want.pump_level));
		compare_field("phase_code", 32'(got.phase_code), 32'(want.phase_code));
		compare_field("flush_state", 32'(got.flush_state), 32'(want.flush_state));
		compare_field("cycle_number", 32'(got.cycle_number), 32'(want.cycle_number));
		compare_field("last_peak", 32'(got.last_peak), 32'(want.last_peak));
		compare_field("last_reached_max", 32'(got.last_reached_max),
			32'(want.last_reached_max));
		compare_field("active", 32'(got.active), 32'(want.active));
		compare_field("padding", 32'(got.pad), 32'(want.pad));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_status(bcs_pkg::result_t'(m_tdata));
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic int draw_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Output side: random stalls, plus a long hold-off when asked for
	initial begin : result_sink
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else begin
				if (stall == 0)
					stall = draw_gap(sink_stalls);
				if (stall > 0) begin
					m_tready <= 1'b0;
					stall--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("backflush_cleaning_sequencer_top verification failed");
		$finish;
	end

	function automatic bcs_pkg::item_t mk_tick(input int p, input int start, input int stop,
			input int cont, input int abort, input int brew);
		bcs_pkg::item_t it;
		it              = '0;
		it.pressure     = p[PRESS_W-1:0];
		it.start_req    = start[0];
		it.stop_req     = stop[0];
		it.continue_req = cont[0];
		it.button_abort = abort[0];
		it.brewing      = brew[0];
		return it;
	endfunction

	// Mostly plausible ticks: pressure clustered round the fill limit, starts
	// when idle, confirmations while waiting for the rinse
	function automatic bcs_pkg::item_t draw_tick(input int noise);
		bcs_pkg::item_t it;
		int    lim;
		int    lo;
		int    hi;
		int    r;
		it  = '0;
		lim = int'(seq_cfg.max_pressure);
		r   = $urandom_range(0, 99);
		if (r < 15) begin
			it.pressure = PRESS_W'($urandom_range(0, 4095));
		end else if (r < 50) begin
			it.pressure = PRESS_W'($urandom_range(0, lim));
		end else if (r < 88) begin
			lo = (lim > 40) ? lim - 40 : 0;
			hi = (lim + 120 > 4095) ? 4095 : lim + 120;
			it.pressure = PRESS_W'($urandom_range(lo, hi));
		end else begin
			lo = (lim + 101 > 4095) ? 4095 : lim + 101;
			it.pressure = PRESS_W'($urandom_range(lo, 4095));
		end
		it.start_req    = $urandom_range(0, 999) < (seq_active() ? 15 : 200);
		it.continue_req = $urandom_range(0, 999) < (seq_phase == bcs_pkg::PC_AWAIT ? 250 : 20);
		it.stop_req     = $urandom_range(0, 999) < noise;
		it.button_abort = $urandom_range(0, 999) < noise;
		it.brewing      = $urandom_range(0, 999) < 150;
		return it;
	endfunction

	function automatic logic [TICK_W-1:0] draw_ticks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 13)
			return bcs_pkg::TICK_MAX;
		if (r < 90)
			return TICK_W'($urandom_range(1, 6));
		return TICK_W'($urandom_range(7, 40));
	endfunction

	function automatic bcs_pkg::cfg_t draw_settings();
		bcs_pkg::cfg_t c;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 10)
			c.max_pressure = '0;
		else if (r < 20)
			c.max_pressure = '1;
		else
			c.max_pressure = PRESS_W'($urandom_range(100, 1500));
		c.fill_timeout_ticks  = draw_ticks();
		c.hold_ticks          = draw_ticks();
		c.hold_pump_level     = LEVEL_W'($urandom_range(0, 255));
		c.pause_ticks         = draw_ticks();
		r = $urandom_range(0, 99);
		if (r < 10)
			c.flushes_per_phase = '0;
		else if (r < 15)
			c.flushes_per_phase = '1;
		else
			c.flushes_per_phase = IDX_W'($urandom_range(1, 4));
		c.soak_ticks          = draw_ticks();
		c.await_timeout_ticks = draw_ticks();
		return c;
	endfunction

	// Leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_setting(input bcs_pkg::cfg_reg_t idx, input logic [TICK_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		store_setting(idx, v);
		@(negedge clk);
	endtask

	task automatic load_settings(input bcs_pkg::cfg_t c);
		write_setting(bcs_pkg::REG_MAX_PRESSURE, TICK_W'(c.max_pressure));
		write_setting(bcs_pkg::REG_FILL_TIMEOUT, c.fill_timeout_ticks);
		write_setting(bcs_pkg::REG_HOLD_TICKS, c.hold_ticks);
		write_setting(bcs_pkg::REG_HOLD_LEVEL, TICK_W'(c.hold_pump_level));
		write_setting(bcs_pkg::REG_PAUSE_TICKS, c.pause_ticks);
		write_setting(bcs_pkg::REG_FLUSHES, TICK_W'(c.flushes_per_phase));
		write_setting(bcs_pkg::REG_SOAK_TICKS, c.soak_ticks);
		write_setting(bcs_pkg::REG_AWAIT_TIMEOUT, c.await_timeout_ticks);
		cfg_valid <= 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_tick(input bcs_pkg::item_t it);
		int gap;
		gap = draw_gap(feed_gaps);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		do @(posedge clk); while (!s_tready);
		status_queue.push_back(advance_sequencer(it));
		@(negedge clk);
	endtask

	task automatic run_ticks(input int count, input int noise);
		for (int i = 0; i < count; i++)
			send_tick(draw_tick(noise));
	endtask

	// Drop valid and wait for every outstanding status word
	task automatic settle();
		s_tvalid <= 1'b0;
		while (status_queue.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		feed_gaps   = 1'b0;
		sink_stalls = 1'b1;
		send_tick(mk_tick(100, 0, 0, 0, 0, 0));
		// requests that mean nothing while idle
		send_tick(mk_tick(100, 0, 1, 1, 1, 0));
		send_tick(mk_tick(100, 1, 0, 0, 0, 1));
		send_tick(mk_tick(0, 1, 0, 0, 0, 0));
		send_tick(mk_tick(300, 1, 0, 0, 0, 0));
		send_tick(mk_tick(950, 0, 0, 1, 0, 0));
		send_tick(mk_tick(980, 0, 0, 0, 0, 0));
		send_tick(mk_tick(1001, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 1, 1, 0, 0, 0));
		// stop and restart together while running: pulses cancel
		send_tick(mk_tick(500, 1, 1, 0, 0, 0));
		send_tick(mk_tick(500, 1, 0, 0, 1, 0));
		send_tick(mk_tick(500, 0, 0, 0, 1, 0));
		send_tick(mk_tick(500, 1, 0, 0, 0, 0));
		send_tick(mk_tick(4095, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 0, 1, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 0));
		settle();
	endtask

	// Every wait ends on the tick after entry; limit 0 is reached at once
	task automatic test_zero_settings();
		bcs_pkg::cfg_t c;
		c = '0;
		load_settings(c);
		feed_gaps = 1'b1;
		send_tick(mk_tick(101, 1, 0, 0, 0, 0));
		send_tick(mk_tick(50, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 1, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(7, 1, 0, 0, 0, 0));
		repeat (4) send_tick(mk_tick(0, 0, 0, 0, 0, 0));
		settle();
	endtask

	// Saturated timers: nothing ends on its own, only stop and abort escape
	task automatic test_extreme_settings();
		bcs_pkg::cfg_t c;
		c.max_pressure        = '1;
		c.fill_timeout_ticks  = bcs_pkg::TICK_MAX;
		c.hold_ticks          = bcs_pkg::TICK_MAX;
		c.hold_pump_level     = '1;
		c.pause_ticks         = bcs_pkg::TICK_MAX;
		c.flushes_per_phase   = '1;
		c.soak_ticks          = bcs_pkg::TICK_MAX;
		c.await_timeout_ticks = bcs_pkg::TICK_MAX;
		load_settings(c);
		send_tick(mk_tick(4095, 1, 0, 0, 0, 0));
		run_ticks(60, 20);
		settle();
	endtask

	// Hold the output long enough for the block to fill and stall its input
	task automatic test_output_stall();
		feed_gaps = 1'b0;
		sink_hold = 300;
		run_ticks(40, NOISE_QUIET);
		settle();
	endtask

	task automatic test_random_settings();
		for (int run = 0; run < RANDOM_RUNS; run++) begin
			load_settings(draw_settings());
			feed_gaps   = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			run_ticks(TICKS_PER_RUN, ($urandom_range(0, 4) == 0) ? NOISE_ROUGH : NOISE_QUIET);
			settle();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		reset_sequencer();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_zero_settings();
		test_extreme_settings();
		test_output_stall();
		test_random_settings();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("backflush_cleaning_sequencer_top verification clean");
		else
			$display("backflush_cleaning_sequencer_top verification failed");
		$finish;
	end

endmodule
